>>> rtl/cds_pkg.sv
// shared types and constants of the drive supervisor
package cds_pkg;

    localparam logic [10:0] ID_CLASS_MASK = 11'h7F0;
    localparam logic [10:0] ID_EMCY       = 11'h080;
    localparam logic [10:0] ID_VELFB      = 11'h180;
    localparam logic [10:0] ID_STATUS     = 11'h280;
    localparam logic [10:0] ID_RPDO       = 11'h200;
    localparam logic [10:0] ID_SDO        = 11'h600;
    localparam logic [10:0] ID_SYNC       = 11'h080;

    localparam logic [15:0] STATUS_FAULT  = 16'h0008;
    localparam logic [15:0] SW_TARGET     = 16'h0400;
    localparam logic [15:0] CWV_RESET     = 16'h0080;
    localparam logic [15:0] CWV_SHUTDOWN  = 16'h0006;
    localparam logic [15:0] CWV_ENABLE    = 16'h000F;
    localparam logic [15:0] OBJ_CW        = 16'h6040;
    localparam logic [7:0]  SDO_WRITE4    = 8'h2B;

    localparam logic [3:0]  LEN_SDO       = 4'd8;
    localparam logic [3:0]  LEN_RPDO      = 4'd4;
    localparam logic [3:0]  LEN_SYNC      = 4'd0;
    localparam logic [3:0]  LEN_STATUS_MIN = 4'd2;

    localparam logic [1:0]  CMD_EMCY      = 2'd0;
    localparam logic [1:0]  CMD_STATUS    = 2'd1;
    localparam logic [1:0]  CMD_TICK      = 2'd2;

    localparam logic [1:0]  CW_NONE       = 2'd0;
    localparam logic [1:0]  CW_RESET      = 2'd1;
    localparam logic [1:0]  CW_SHUTDOWN   = 2'd2;
    localparam logic [1:0]  CW_ENABLE     = 2'd3;

    localparam logic [2:0]  CFG_STEER     = 3'd0;
    localparam logic [2:0]  CFG_TRAVEL    = 3'd1;
    localparam logic [2:0]  CFG_MASK      = 3'd2;
    localparam logic [2:0]  CFG_WAIT      = 3'd3;
    localparam logic [2:0]  CFG_LIMIT     = 3'd4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  node;
        logic [15:0] status;
    } t_cmd;

    typedef struct packed {
        logic [30:0] steer_speed;
        logic [30:0] travel_speed;
        logic [15:0] steer_mask;
        logic [7:0]  wait_cycles;
        logic [15:0] hb_limit;
    } t_cfg;

    function automatic logic [15:0] cw_value(input logic [1:0] code);
        logic [15:0] v;
        case (code)
            CW_RESET:    v = CWV_RESET;
            CW_SHUTDOWN: v = CWV_SHUTDOWN;
            CW_ENABLE:   v = CWV_ENABLE;
            default:     v = 16'h0000;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/canopen_drive_supervisor_core.sv
// top level of the drive supervisor: config registers, classifier, queue, sequencer
//
// input channel (valid/stall) takes one request per cycle while o_in_stall is low:
// a received CAN frame (i_action low) or a control cycle tick (i_action high). frame
// requests update the state of drive nodes 1..NODES and produce no output; unknown
// ids are dropped. the classifier feeds a four-entry command queue; o_in_stall is
// high while it is full. a frame request updates node state as it leaves the queue.
// a tick walks the nodes, one per cycle, then emits its output frames: NODES
// velocity frames, one SDO per recovery step due, one SYNC with o_last_frame set.
// every output frame carries the fault and timeout flags as at the end of its tick.
// the output stage is a register: when i_out_stall is high the frame holds and the
// sequencer waits; the queue keeps taking requests until it fills.
// i_cfg_wr_en writes register i_cfg_index at once; writes are expected while idle.
// synchronous active-low reset clears node state, queue and output valid, and loads
// the register defaults.
module canopen_drive_supervisor_core #(
    parameter int NODES = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [10:0] i_can_id,
    input  logic [3:0]  i_frame_len,
    input  logic [31:0] i_payload_low,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_tx_id,
    output logic [3:0]  o_tx_len,
    output logic [63:0] o_tx_data,
    output logic [15:0] o_fault_flags,
    output logic [15:0] o_timeout_flags,
    output logic        o_last_frame
);
    import cds_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steer_speed  <= 31'd252586;
            r_cfg.travel_speed <= 31'd27306;
            r_cfg.steer_mask   <= 16'd84;
            r_cfg.wait_cycles  <= 8'd50;
            r_cfg.hb_limit     <= 16'd250;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_STEER:  r_cfg.steer_speed  <= i_cfg_data;
                CFG_TRAVEL: r_cfg.travel_speed <= i_cfg_data;
                CFG_MASK:   r_cfg.steer_mask   <= i_cfg_data[15:0];
                CFG_WAIT:   r_cfg.wait_cycles  <= i_cfg_data[7:0];
                CFG_LIMIT:  r_cfg.hb_limit     <= i_cfg_data[15:0];
                default:    r_cfg              <= r_cfg;
            endcase
        end
    end

    cds_front #(.NODES(NODES)) u_front (
        .i_in_valid    (i_in_valid),
        .i_action      (i_action),
        .i_can_id      (i_can_id),
        .i_frame_len   (i_frame_len),
        .i_payload_low (i_payload_low),
        .i_full        (full),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    cds_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_data  (head_cmd)
    );

    cds_back #(.NODES(NODES)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd_valid     (head_valid),
        .i_cmd           (head_cmd),
        .o_cmd_pop       (pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_tx_id         (o_tx_id),
        .o_tx_len        (o_tx_len),
        .o_tx_data       (o_tx_data),
        .o_fault_flags   (o_fault_flags),
        .o_timeout_flags (o_timeout_flags),
        .o_last_frame    (o_last_frame)
    );

endmodule

>>> rtl/cds_front.sv
// request classifier: sorts received frames and ticks into back-end commands
module cds_front #(
    parameter int NODES = 6
) (
    input  logic          i_in_valid,
    input  logic          i_action,
    input  logic [10:0]   i_can_id,
    input  logic [3:0]    i_frame_len,
    input  logic [31:0]   i_payload_low,
    input  logic          i_full,
    output logic          o_in_stall,
    output logic          o_push,
    output cds_pkg::t_cmd o_cmd
);
    import cds_pkg::*;

    logic [3:0] node_id;
    logic       node_ok;
    logic       keep;

    assign node_id = i_can_id[3:0];
    assign node_ok = (node_id != 4'd0) && (node_id <= 4'(NODES));
    assign o_in_stall = i_full;

    always_comb begin
        keep         = 1'b0;
        o_cmd.kind   = CMD_TICK;
        o_cmd.node   = node_id - 4'd1;
        o_cmd.status = i_payload_low[15:0];
        if (i_action) begin
            keep = 1'b1;
        end else if (node_ok) begin
            case (i_can_id & ID_CLASS_MASK)
                ID_EMCY: begin
                    keep       = 1'b1;
                    o_cmd.kind = CMD_EMCY;
                end
                ID_STATUS: begin
                    keep       = (i_frame_len >= LEN_STATUS_MIN);
                    o_cmd.kind = CMD_STATUS;
                end
                ID_VELFB: begin
                    keep = 1'b0;
                end
                default: begin
                    keep = 1'b0;
                end
            endcase
        end
    end

    assign o_push = i_in_valid && !i_full && keep;

endmodule

>>> rtl/cds_fifo.sv
// short command queue between classifier and node sequencer
module cds_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cds_pkg::t_cmd i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output cds_pkg::t_cmd o_data
);
    import cds_pkg::*;

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/cds_back.sv
// node sequencer: per-node state, recovery walk and frame emission
module cds_back #(
    parameter int NODES = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cds_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    input  cds_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic [10:0]   o_tx_id,
    output logic [3:0]    o_tx_len,
    output logic [63:0]   o_tx_data,
    output logic [15:0]   o_fault_flags,
    output logic [15:0]   o_timeout_flags,
    output logic          o_last_frame
);
    import cds_pkg::*;

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int PW = $clog2(NODES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]    r_state;
    logic [PW-1:0] r_ptr;
    logic          r_phase;

    logic          r_rev   [NODES];
    logic [15:0]   r_now   [NODES];
    logic [15:0]   r_prev  [NODES];
    logic          r_seen  [NODES];
    logic          r_fault [NODES];
    logic          r_rec   [NODES];
    logic [1:0]    r_step  [NODES];
    logic [7:0]    r_wait  [NODES];
    logic [15:0]   r_sil   [NODES];
    logic          r_to    [NODES];
    logic [1:0]    r_code  [NODES];
    logic [31:0]   r_vel   [NODES];

    logic          r_out_valid;
    logic [10:0]   r_tx_id;
    logic [3:0]    r_tx_len;
    logic [63:0]   r_tx_data;
    logic [15:0]   r_fault_flags;
    logic [15:0]   r_timeout_flags;
    logic          r_last_frame;

    logic [IW-1:0] wi;
    logic [IW-1:0] ci;
    logic [3:0]    node_id;
    logic          fault_in;
    logic          n_rev;
    logic [15:0]   n_prev;
    logic          n_fault;
    logic          n_rec;
    logic [1:0]    n_step;
    logic [7:0]    n_wait;
    logic [15:0]   n_sil;
    logic          n_to;
    logic [1:0]    n_code;
    logic [31:0]   n_vel;
    logic [30:0]   mag;
    logic [15:0]   fault_vec;
    logic [15:0]   timeout_vec;
    logic          out_free;

    assign wi       = r_ptr[IW-1:0];
    assign ci       = i_cmd.node[IW-1:0];
    assign node_id  = 4'(r_ptr) + 4'd1;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    // per-node walk step
    always_comb begin
        fault_in = r_fault[wi] || (r_seen[wi] && ((r_now[wi] & STATUS_FAULT) != 16'h0000));
        n_rev    = r_rev[wi];
        n_fault  = r_fault[wi];
        n_rec    = r_rec[wi];
        n_step   = r_step[wi];
        n_wait   = r_wait[wi];
        n_to     = r_to[wi];
        n_code   = CW_NONE;
        n_vel    = 32'h0;
        mag      = i_cfg.steer_mask[node_id] ? i_cfg.steer_speed : i_cfg.travel_speed;
        if (fault_in) begin
            n_fault = 1'b1;
            if (!r_rec[wi]) begin
                n_rec  = 1'b1;
                n_step = 2'd0;
                n_wait = 8'd0;
            end
        end else if (r_seen[wi] && ((r_now[wi] & SW_TARGET) != 16'h0000)
                     && ((r_prev[wi] & SW_TARGET) == 16'h0000)) begin
            n_rev = ~r_rev[wi];
        end
        n_prev = r_seen[wi] ? r_now[wi] : r_prev[wi];
        n_sil  = (r_sil[wi] == 16'hFFFF) ? r_sil[wi] : r_sil[wi] + 16'd1;
        if (n_sil > i_cfg.hb_limit) begin
            n_to = 1'b1;
        end
        if (n_rec) begin
            n_wait = n_wait + 8'd1;
            if (n_wait >= i_cfg.wait_cycles) begin
                n_wait = 8'd0;
                case (n_step)
                    2'd0: begin
                        n_code = CW_RESET;
                        n_step = 2'd1;
                    end
                    2'd1: begin
                        n_code = CW_SHUTDOWN;
                        n_step = 2'd2;
                    end
                    2'd2: begin
                        n_code = CW_ENABLE;
                        n_step = 2'd3;
                    end
                    default: begin
                        n_fault = 1'b0;
                        n_to    = 1'b0;
                        n_rec   = 1'b0;
                        n_sil   = 16'd0;
                    end
                endcase
            end
        end else begin
            n_vel = n_rev ? (32'h0 - {1'b0, mag}) : {1'b0, mag};
        end
    end

    always_comb begin
        fault_vec   = 16'h0000;
        timeout_vec = 16'h0000;
        for (int n = 0; n < NODES; n++) begin
            fault_vec[n+1]   = r_fault[n];
            timeout_vec[n+1] = r_to[n];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int n = 0; n < NODES; n++) begin
                r_rev[n]   <= 1'b0;
                r_now[n]   <= 16'h0;
                r_prev[n]  <= 16'h0;
                r_seen[n]  <= 1'b0;
                r_fault[n] <= 1'b0;
                r_rec[n]   <= 1'b0;
                r_step[n]  <= 2'd0;
                r_wait[n]  <= 8'd0;
                r_sil[n]   <= 16'h0;
                r_to[n]    <= 1'b0;
            end
        end else begin
            if (out_free) begin
                r_out_valid <= (r_state == S_EMIT);
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        case (i_cmd.kind)
                            CMD_EMCY: begin
                                r_fault[ci] <= 1'b1;
                            end
                            CMD_STATUS: begin
                                r_now[ci]  <= i_cmd.status;
                                r_seen[ci] <= 1'b1;
                                r_sil[ci]  <= 16'h0;
                                r_to[ci]   <= 1'b0;
                            end
                            CMD_TICK: begin
                                r_ptr   <= '0;
                                r_state <= S_WALK;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    r_rev[wi]   <= n_rev;
                    r_prev[wi]  <= n_prev;
                    r_seen[wi]  <= 1'b0;
                    r_fault[wi] <= n_fault;
                    r_rec[wi]   <= n_rec;
                    r_step[wi]  <= n_step;
                    r_wait[wi]  <= n_wait;
                    r_sil[wi]   <= n_sil;
                    r_to[wi]    <= n_to;
                    if (r_ptr == PW'(NODES - 1)) begin
                        r_ptr   <= '0;
                        r_phase <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (r_ptr == PW'(NODES)) begin
                            r_state <= S_IDLE;
                        end else if (!r_phase && (r_code[wi] != CW_NONE)) begin
                            r_phase <= 1'b1;
                        end else begin
                            r_phase <= 1'b0;
                            r_ptr   <= r_ptr + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // walk results kept for emission
    always_ff @(posedge i_clk) begin
        if (r_state == S_WALK) begin
            r_code[wi] <= n_code;
            r_vel[wi]  <= n_vel;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && out_free) begin
            r_fault_flags   <= fault_vec;
            r_timeout_flags <= timeout_vec;
            if (r_ptr == PW'(NODES)) begin
                r_tx_id      <= ID_SYNC;
                r_tx_len     <= LEN_SYNC;
                r_tx_data    <= 64'h0;
                r_last_frame <= 1'b1;
            end else if (!r_phase && (r_code[wi] != CW_NONE)) begin
                r_tx_id      <= ID_SDO + 11'(node_id);
                r_tx_len     <= LEN_SDO;
                r_tx_data    <= {16'h0000, cw_value(r_code[wi]), 8'h00, OBJ_CW, SDO_WRITE4};
                r_last_frame <= 1'b0;
            end else begin
                r_tx_id      <= ID_RPDO + 11'(node_id);
                r_tx_len     <= LEN_RPDO;
                r_tx_data    <= {32'h0, r_vel[wi]};
                r_last_frame <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tx_id         = r_tx_id;
    assign o_tx_len        = r_tx_len;
    assign o_tx_data       = r_tx_data;
    assign o_fault_flags   = r_fault_flags;
    assign o_timeout_flags = r_timeout_flags;
    assign o_last_frame    = r_last_frame;

endmodule

>>> rtl/cds_checker.sv
// port-level checks of the drive supervisor and their bind
module cds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [10:0] o_tx_id,
    input logic [3:0]  o_tx_len,
    input logic [63:0] o_tx_data,
    input logic [15:0] o_fault_flags,
    input logic [15:0] o_timeout_flags,
    input logic        o_last_frame
);
    import cds_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_sync_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_frame) |->
            (o_tx_id == ID_SYNC) && (o_tx_len == LEN_SYNC) && (o_tx_data == 64'h0))
        else $error("closing frame is not a plain sync");

    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_frame) |-> (o_tx_len == LEN_RPDO) || (o_tx_len == LEN_SDO))
        else $error("node frame with wrong length");

    a_no_node0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_fault_flags[0] && !o_timeout_flags[0])
        else $error("flag set for node zero");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            o_out_valid && $stable(o_tx_id) && $stable(o_tx_data) && $stable(o_last_frame))
        else $error("stalled request changed");

endmodule

bind canopen_drive_supervisor_core cds_checker u_cds_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_tx_id         (o_tx_id),
    .o_tx_len        (o_tx_len),
    .o_tx_data       (o_tx_data),
    .o_fault_flags   (o_fault_flags),
    .o_timeout_flags (o_timeout_flags),
    .o_last_frame    (o_last_frame)
);
